// ===== sv/utfd_pkg.sv =====
// Shared types and constants for the text code point decoder.
`default_nettype none

package utfd_pkg;

	// Encoding selected by the configuration register
	typedef enum logic [1:0] {
		MODE_RAW     = 2'd0,
		MODE_UTF8    = 2'd1,
		MODE_UTF16LE = 2'd2,
		MODE_UTF16BE = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_INVALID = 2'd1,
		ST_TRUNC   = 2'd2
	} status_t;

	// UTF-8 byte classes found by the front end
	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_CONT  = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD   = 3'd5
	} cls_t;

	localparam int CP_W = 21;

	// Top six bits of a UTF-16 unit that mark high and low surrogates
	localparam logic [5:0] HI_SURR_TAG = 6'h36;
	localparam logic [5:0] LO_SURR_TAG = 6'h37;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// Input beat
	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} in_beat_t;

	// Result beat
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		status_t         status;
	} out_beat_t;

	// Classified beat passed from front to back
	typedef struct packed {
		mode_t      mode;
		logic       eos;
		logic [7:0] data;
		cls_t       cls;
	} mid_beat_t;

endpackage

`default_nettype wire

// ===== sv/utf_text_codepoint_decoder_top.sv =====
// Top level of the text code point decoder.
//
// Input channel: drive item and raise push; a beat is taken on a clock edge
// where push is high and full is low. A beat with end_of_stream set flushes
// any partial character as a truncation result; its byte is ignored.
// Result channel: while empty is low the oldest result is on result; it is
// taken on a clock edge where pop is high. Error results carry code point 0.
// Configuration: cfg_we writes cfg_data into the encoding register (0 raw,
// 1 UTF-8, 2 UTF-16LE, 3 UTF-16BE) and clears any partial character; write
// only while the block is idle.
// Path: an accepted beat is registered in the inner queue, then decoded by the
// back end, which registers its result in the output queue for popping.
// Throughput: one byte per cycle while the output queue has room; two-entry
// queues sit between front and back and at the output.
// When the receiver stalls the output queue fills with two results, then the
// inner queue with two beats, and full rises; beats that give no result, such
// as UTF-8 lead bytes or the first byte of a UTF-16 unit, keep flowing until
// then. Reset empties both queues, clears the decode state and selects UTF-8.
`default_nettype none

module utf_text_codepoint_decoder_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire utfd_pkg::in_beat_t item,
	output logic                    empty,
	input  wire logic               pop,
	output utfd_pkg::out_beat_t     result,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_data
);

	utfd_pkg::mode_t     mode_q;
	logic                mid_valid;
	logic                mid_take;
	utfd_pkg::mid_beat_t mid_item;

	// Encoding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= utfd_pkg::MODE_UTF8;
		end else if (cfg_we) begin
			mode_q <= utfd_pkg::mode_t'(cfg_data);
		end
	end

	utfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.push      (push),
		.full      (full),
		.item      (item),
		.mid_valid (mid_valid),
		.mid_item  (mid_item),
		.mid_take  (mid_take)
	);

	utfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.mid_valid (mid_valid),
		.mid_item  (mid_item),
		.mid_take  (mid_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// Error results never carry a code point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status != utfd_pkg::ST_VALID)) |-> (result.code_point == '0))
		else $error("error result with nonzero code point");

	// An accepted beat is waiting in the inner queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> mid_valid)
		else $error("accepted beat missing from inner queue");

	// Backpressure only with a loaded inner queue
	a_full_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_valid)
		else $error("full raised with empty inner queue");

endmodule

`default_nettype wire

// ===== sv/utfd_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none

module utfd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire utfd_pkg::mode_t    mode,
	input  wire logic               push,
	output logic                    full,
	input  wire utfd_pkg::in_beat_t item,
	output logic                    mid_valid,
	output utfd_pkg::mid_beat_t     mid_item,
	input  wire logic               mid_take
);

	utfd_pkg::mid_beat_t mem_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;
	utfd_pkg::mid_beat_t cls_beat;
	logic                do_push;
	logic                do_pop;

	// Byte classification for UTF-8 lead and continuation bytes
	always_comb begin
		cls_beat.mode = mode;
		cls_beat.eos  = item.end_of_stream;
		cls_beat.data = item.byte_value;
		if (!item.byte_value[7]) begin
			cls_beat.cls = utfd_pkg::CLS_ASCII;
		end else if (item.byte_value[7:6] == 2'b10) begin
			cls_beat.cls = utfd_pkg::CLS_CONT;
		end else if (item.byte_value[7:5] == 3'b110) begin
			cls_beat.cls = utfd_pkg::CLS_LEAD2;
		end else if (item.byte_value[7:4] == 4'b1110) begin
			cls_beat.cls = utfd_pkg::CLS_LEAD3;
		end else if (item.byte_value[7:3] == 5'b11110) begin
			cls_beat.cls = utfd_pkg::CLS_LEAD4;
		end else begin
			cls_beat.cls = utfd_pkg::CLS_BAD;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign mid_valid = (cnt_q != 2'd0);
	assign mid_item  = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = mid_take && mid_valid;

	// Two-entry queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= cls_beat;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

// ===== sv/utfd_back.sv =====
// Back end: decode state machine over classified beats, plus the result queue.
`default_nettype none

module utfd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                mid_valid,
	input  wire utfd_pkg::mid_beat_t mid_item,
	output logic                     mid_take,
	output logic                     empty,
	input  wire logic                pop,
	output utfd_pkg::out_beat_t      result
);

	// Decode state
	logic [1:0]                pend_q;
	logic [utfd_pkg::CP_W-1:0] acc_q;
	logic [7:0]                held_q;
	logic                      phase_q;
	logic                      surr_q;

	logic [1:0]                pend_d;
	logic [utfd_pkg::CP_W-1:0] acc_d;
	logic [7:0]                held_d;
	logic                      phase_d;
	logic                      surr_d;

	logic                      emit;
	utfd_pkg::out_beat_t       res;
	logic [15:0]               unit;
	logic [utfd_pkg::CP_W-1:0] acc_shift;

	// Result queue
	utfd_pkg::out_beat_t out_mem_q [2];
	logic                owr_q;
	logic                ord_q;
	logic [1:0]          ocnt_q;
	logic                do_pop;

	assign mid_take  = mid_valid && (ocnt_q != 2'd2);
	assign unit      = (mid_item.mode == utfd_pkg::MODE_UTF16BE) ?
	                   {held_q, mid_item.data} : {mid_item.data, held_q};
	assign acc_shift = {acc_q[utfd_pkg::CP_W-7:0], mid_item.data[5:0]};

	// Next decode state and result for the beat taken this cycle
	always_comb begin
		pend_d  = pend_q;
		acc_d   = acc_q;
		held_d  = held_q;
		phase_d = phase_q;
		surr_d  = surr_q;
		emit    = 1'b0;
		res.code_point = '0;
		res.status     = utfd_pkg::ST_VALID;
		if (cfg_we) begin
			pend_d  = 2'd0;
			acc_d   = '0;
			held_d  = 8'd0;
			phase_d = 1'b0;
			surr_d  = 1'b0;
		end else if (mid_take) begin
			if (mid_item.eos) begin
				if ((pend_q != 2'd0) || phase_q || surr_q) begin
					emit       = 1'b1;
					res.status = utfd_pkg::ST_TRUNC;
				end
				pend_d  = 2'd0;
				acc_d   = '0;
				held_d  = 8'd0;
				phase_d = 1'b0;
				surr_d  = 1'b0;
			end else begin
				case (mid_item.mode)
					utfd_pkg::MODE_RAW: begin
						emit           = 1'b1;
						res.code_point = {13'd0, mid_item.data};
					end
					utfd_pkg::MODE_UTF8: begin
						if (pend_q != 2'd0) begin
							if (mid_item.cls != utfd_pkg::CLS_CONT) begin
								emit       = 1'b1;
								res.status = utfd_pkg::ST_INVALID;
								pend_d     = 2'd0;
								acc_d      = '0;
							end else if (pend_q == 2'd1) begin
								emit           = 1'b1;
								res.code_point = acc_shift;
								pend_d         = 2'd0;
								acc_d          = '0;
							end else begin
								acc_d  = acc_shift;
								pend_d = pend_q - 2'd1;
							end
						end else begin
							case (mid_item.cls)
								utfd_pkg::CLS_ASCII: begin
									emit           = 1'b1;
									res.code_point = {13'd0, mid_item.data};
								end
								utfd_pkg::CLS_LEAD2: begin
									acc_d  = {16'd0, mid_item.data[4:0]};
									pend_d = 2'd1;
								end
								utfd_pkg::CLS_LEAD3: begin
									acc_d  = {17'd0, mid_item.data[3:0]};
									pend_d = 2'd2;
								end
								utfd_pkg::CLS_LEAD4: begin
									acc_d  = {18'd0, mid_item.data[2:0]};
									pend_d = 2'd3;
								end
								default: begin
									// stray continuation or lead byte 0xF8 and up
									emit       = 1'b1;
									res.status = utfd_pkg::ST_INVALID;
								end
							endcase
						end
					end
					default: begin
						// UTF-16, either byte order
						if (!phase_q) begin
							held_d  = mid_item.data;
							phase_d = 1'b1;
						end else begin
							phase_d = 1'b0;
							held_d  = 8'd0;
							if (surr_q) begin
								emit   = 1'b1;
								surr_d = 1'b0;
								acc_d  = '0;
								if (unit[15:10] != utfd_pkg::LO_SURR_TAG) begin
									res.status = utfd_pkg::ST_INVALID;
								end else begin
									res.code_point = {acc_q[utfd_pkg::CP_W-1:10], unit[9:0]}
									                 + utfd_pkg::SUPP_BASE;
								end
							end else if (unit[15:10] == utfd_pkg::HI_SURR_TAG) begin
								acc_d  = {1'b0, unit[9:0], 10'd0};
								surr_d = 1'b1;
							end else begin
								emit           = 1'b1;
								res.code_point = {5'd0, unit};
							end
						end
					end
				endcase
			end
		end
	end

	// Decode state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			acc_q   <= '0;
			held_q  <= 8'd0;
			phase_q <= 1'b0;
			surr_q  <= 1'b0;
		end else begin
			pend_q  <= pend_d;
			acc_q   <= acc_d;
			held_q  <= held_d;
			phase_q <= phase_d;
			surr_q  <= surr_d;
		end
	end

	assign empty  = (ocnt_q == 2'd0);
	assign result = out_mem_q[ord_q];
	assign do_pop = pop && !empty;

	// Result queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			out_mem_q[owr_q] <= res;
		end
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (emit) begin
				owr_q <= ~owr_q;
			end
			if (do_pop) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, emit} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire
